// ===== design/qvp_pkg.sv =====
// qvp_pkg: shared types and constants for the quaternion vertex projection core.
// Payload structs, register indexes, reset values and factor limits.
// No dependencies.
`default_nettype none

package qvp_pkg;

   // Vertex coordinate width (signed Q4.12 at the default of 16)
   localparam int COORD_WIDTH = 16;

   // Register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_W    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_X    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_Y    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_Z    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEPTH    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_X = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Y = 3'd7;

   // Register reset values
   localparam logic signed [15:0] RST_ROT_W    = 16'sd16384;
   localparam logic signed [15:0] RST_ROT_XYZ  = 16'sd0;
   localparam logic        [15:0] RST_DEPTH    = 16'd768;
   localparam logic        [15:0] RST_SCALE    = 16'd6400;
   localparam logic signed [15:0] RST_OFFSET   = 16'sd0;

   // Perspective factor limits, unsigned Q4.12 (0.1 and 10.0)
   localparam logic [15:0] FACTOR_MIN = 16'd410;
   localparam logic [15:0] FACTOR_MAX = 16'd40960;

   // How the perspective factor is chosen for one vertex
   typedef enum logic [1:0] {
      FMODE_DIV,   // quotient of the divider, floored at FACTOR_MIN
      FMODE_MAX,   // zero denominator or quotient at/above the ceiling
      FMODE_MIN    // negative denominator
   } fmode_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic signed [COORD_WIDTH-1:0] vertex_z;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== design/quaternion_vertex_projection_core.sv =====
// quaternion_vertex_projection_core: rotates a vertex by a unit quaternion and projects
// it to screen space with a clamped perspective factor. Fully pipelined.
// Depends on qvp_pkg.
`default_nettype none

// The core takes one vertex per cycle on the req channel while req_ready is high and
// returns its screen point on the rsp channel, in order. The work runs through 26
// register stages: two for the quaternion terms (products, then rounded dot/cross
// sums), two for the rotated point, one for the denominator 2*depth - z and the
// coordinate clamp, one for the factor range check, sixteen restoring-divider stages that
// each resolve one quotient bit, and four for scale*factor and the final products; the
// offset add and 16-bit saturation feed the output register. A second output register
// (skid) catches the item leaving the pipe when rsp stalls, so req_ready drops only when
// both are full, and it is registered. Registers are written through csr_we/csr_index/
// csr_wdata with no wait state; write them only with nothing in flight, since stages read
// the live register values. The quaternion is used as written, not normalized, so a
// non-unit q scales the result by |q|^2. A zero denominator gives factor 10, a negative
// one gives 0.1, and the factor is otherwise clamped to [0.1, 10]. Outputs are Q12.4.

module quaternion_vertex_projection_core
   import qvp_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire req_data_type                req_data,

   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      rsp_data_type                rsp_data,

   input  wire logic                        csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [15:0]                 csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Widths
   // ---------------------------------------------------------------------------------
   localparam int CW    = COORD_WIDTH;
   localparam int P1W   = CW + 16;          // q component * coordinate
   localparam int ASUMW = 34;               // w^2 - |u|^2 at Q.28
   localparam int A14W  = 19;               // rounded a at Q.14
   localparam int DSUMW = CW + 18;          // dot / cross sums at Q.26
   localparam int DW    = CW + 3;           // rounded dot / cross at Q.12
   localparam int M3W   = CW + 19;          // second-level products
   localparam int SW    = CW + 21;          // rotated coordinate sum at Q.26
   localparam int PW    = CW + 7;           // rotated coordinate at Q.12
   localparam int PCW   = 38;               // clamped coordinate, +-2^36
   localparam int CMPW  = ((PW > PCW) ? PW : PCW) + 1;
   localparam int TWODW = 22;               // 2*depth at Q.12 (21 bits) as signed
   localparam int DENS  = ((PW > TWODW) ? PW : TWODW) + 2;
   localparam int RW    = DENS - 1;         // positive denominator / remainder
   localparam int QW    = 16;               // quotient bits
   localparam int CHKW  = RW + 16;          // 40960 * denominator
   localparam int SFW   = 26;               // scale * factor at Q.12
   localparam int LW    = 19;               // low slice of the clamped coordinate
   localparam int HW    = PCW - LW;         // high (signed) slice
   localparam int HPW   = HW + SFW + 1;
   localparam int LPW   = LW + SFW;
   localparam int FULLW = 64;
   localparam int SXW   = 44;               // projected term at Q.4
   localparam int OW    = SXW + 2;

   // Stage indexes in the valid chain
   localparam int NP       = 6 + QW + 4;
   localparam int IDX_DIV0 = 5;             // factor range check stage
   localparam int IDX_DIVN = IDX_DIV0 + QW; // last divider stage

   localparam logic signed [CMPW-1:0] PLIM_POS = CMPW'(64'sd68719476736);
   localparam logic signed [CMPW-1:0] PLIM_NEG = -PLIM_POS;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic signed [15:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   logic        [15:0] depth_ff, scale_ff;
   logic signed [15:0] offset_x_ff, offset_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff    <= RST_ROT_W;
         rot_x_ff    <= RST_ROT_XYZ;
         rot_y_ff    <= RST_ROT_XYZ;
         rot_z_ff    <= RST_ROT_XYZ;
         depth_ff    <= RST_DEPTH;
         scale_ff    <= RST_SCALE;
         offset_x_ff <= RST_OFFSET;
         offset_y_ff <= RST_OFFSET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_W:    rot_w_ff    <= $signed(csr_wdata);
            CSR_ROT_X:    rot_x_ff    <= $signed(csr_wdata);
            CSR_ROT_Y:    rot_y_ff    <= $signed(csr_wdata);
            CSR_ROT_Z:    rot_z_ff    <= $signed(csr_wdata);
            CSR_DEPTH:    depth_ff    <= csr_wdata;
            CSR_SCALE:    scale_ff    <= csr_wdata;
            CSR_OFFSET_X: offset_x_ff <= $signed(csr_wdata);
            CSR_OFFSET_Y: offset_y_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Pipeline control: every stage moves together; it halts only while the skid
   // register is occupied, so nothing is dropped or duplicated on a stall.
   // ---------------------------------------------------------------------------------
   logic          pipe_en;
   logic [NP-1:0] vld_ff, vld_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic          skid_vld_ff, skid_vld_in;

   assign pipe_en   = !skid_vld_ff;
   assign req_ready = pipe_en;
   assign vld_in    = {vld_ff[NP-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: q component products with the vertex, and the squares of q
   // ---------------------------------------------------------------------------------
   logic signed [CW-1:0]  vx, vy, vz;
   logic signed [P1W-1:0] s1_xx_in, s1_yy_in, s1_zz_in, s1_yz_in, s1_zy_in;
   logic signed [P1W-1:0] s1_zx_in, s1_xz_in, s1_xy_in, s1_yx_in;
   logic signed [P1W-1:0] s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_yz_ff, s1_zy_ff;
   logic signed [P1W-1:0] s1_zx_ff, s1_xz_ff, s1_xy_ff, s1_yx_ff;
   logic signed [31:0]    s1_ww_in, s1_ux_in, s1_uy_in, s1_uz_in;
   logic signed [31:0]    s1_ww_ff, s1_ux_ff, s1_uy_ff, s1_uz_ff;
   logic signed [CW-1:0]  s1_vx_ff, s1_vy_ff, s1_vz_ff;

   assign vx = req_data.vertex_x;
   assign vy = req_data.vertex_y;
   assign vz = req_data.vertex_z;

   assign s1_xx_in = P1W'(rot_x_ff) * P1W'(vx);
   assign s1_yy_in = P1W'(rot_y_ff) * P1W'(vy);
   assign s1_zz_in = P1W'(rot_z_ff) * P1W'(vz);
   assign s1_yz_in = P1W'(rot_y_ff) * P1W'(vz);
   assign s1_zy_in = P1W'(rot_z_ff) * P1W'(vy);
   assign s1_zx_in = P1W'(rot_z_ff) * P1W'(vx);
   assign s1_xz_in = P1W'(rot_x_ff) * P1W'(vz);
   assign s1_xy_in = P1W'(rot_x_ff) * P1W'(vy);
   assign s1_yx_in = P1W'(rot_y_ff) * P1W'(vx);
   assign s1_ww_in = 32'(rot_w_ff) * 32'(rot_w_ff);
   assign s1_ux_in = 32'(rot_x_ff) * 32'(rot_x_ff);
   assign s1_uy_in = 32'(rot_y_ff) * 32'(rot_y_ff);
   assign s1_uz_in = 32'(rot_z_ff) * 32'(rot_z_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_xx_ff <= s1_xx_in;
         s1_yy_ff <= s1_yy_in;
         s1_zz_ff <= s1_zz_in;
         s1_yz_ff <= s1_yz_in;
         s1_zy_ff <= s1_zy_in;
         s1_zx_ff <= s1_zx_in;
         s1_xz_ff <= s1_xz_in;
         s1_xy_ff <= s1_xy_in;
         s1_yx_ff <= s1_yx_in;
         s1_ww_ff <= s1_ww_in;
         s1_ux_ff <= s1_ux_in;
         s1_uy_ff <= s1_uy_in;
         s1_uz_ff <= s1_uz_in;
         s1_vx_ff <= vx;
         s1_vy_ff <= vy;
         s1_vz_ff <= vz;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: a = w^2 - |u|^2, d = u.v, c = u x v, each rounded half up
   // ---------------------------------------------------------------------------------
   logic signed [ASUMW-1:0] a_sum;
   logic signed [DSUMW-1:0] d_sum, cx_sum, cy_sum, cz_sum;
   logic signed [A14W-1:0]  s2_a_in, s2_a_ff;
   logic signed [DW-1:0]    s2_d_in, s2_cx_in, s2_cy_in, s2_cz_in;
   logic signed [DW-1:0]    s2_d_ff, s2_cx_ff, s2_cy_ff, s2_cz_ff;
   logic signed [CW-1:0]    s2_vx_ff, s2_vy_ff, s2_vz_ff;

   assign a_sum  = ASUMW'(s1_ww_ff) - ASUMW'(s1_ux_ff) - ASUMW'(s1_uy_ff)
                 - ASUMW'(s1_uz_ff) + ASUMW'(8192);
   assign d_sum  = DSUMW'(s1_xx_ff) + DSUMW'(s1_yy_ff) + DSUMW'(s1_zz_ff) + DSUMW'(8192);
   assign cx_sum = DSUMW'(s1_yz_ff) - DSUMW'(s1_zy_ff) + DSUMW'(8192);
   assign cy_sum = DSUMW'(s1_zx_ff) - DSUMW'(s1_xz_ff) + DSUMW'(8192);
   assign cz_sum = DSUMW'(s1_xy_ff) - DSUMW'(s1_yx_ff) + DSUMW'(8192);

   assign s2_a_in  = A14W'(a_sum >>> 14);
   assign s2_d_in  = DW'(d_sum >>> 14);
   assign s2_cx_in = DW'(cx_sum >>> 14);
   assign s2_cy_in = DW'(cy_sum >>> 14);
   assign s2_cz_in = DW'(cz_sum >>> 14);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_a_ff  <= s2_a_in;
         s2_d_ff  <= s2_d_in;
         s2_cx_ff <= s2_cx_in;
         s2_cy_ff <= s2_cy_in;
         s2_cz_ff <= s2_cz_in;
         s2_vx_ff <= s1_vx_ff;
         s2_vy_ff <= s1_vy_ff;
         s2_vz_ff <= s1_vz_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 3: terms of r = a*v + 2*d*u + 2*w*c
   // ---------------------------------------------------------------------------------
   logic signed [M3W-1:0] s3_avx_in, s3_avy_in, s3_avz_in;
   logic signed [M3W-1:0] s3_dux_in, s3_duy_in, s3_duz_in;
   logic signed [M3W-1:0] s3_wcx_in, s3_wcy_in, s3_wcz_in;
   logic signed [M3W-1:0] s3_avx_ff, s3_avy_ff, s3_avz_ff;
   logic signed [M3W-1:0] s3_dux_ff, s3_duy_ff, s3_duz_ff;
   logic signed [M3W-1:0] s3_wcx_ff, s3_wcy_ff, s3_wcz_ff;

   assign s3_avx_in = M3W'(s2_a_ff) * M3W'(s2_vx_ff);
   assign s3_avy_in = M3W'(s2_a_ff) * M3W'(s2_vy_ff);
   assign s3_avz_in = M3W'(s2_a_ff) * M3W'(s2_vz_ff);
   assign s3_dux_in = M3W'(s2_d_ff) * M3W'(rot_x_ff);
   assign s3_duy_in = M3W'(s2_d_ff) * M3W'(rot_y_ff);
   assign s3_duz_in = M3W'(s2_d_ff) * M3W'(rot_z_ff);
   assign s3_wcx_in = M3W'(rot_w_ff) * M3W'(s2_cx_ff);
   assign s3_wcy_in = M3W'(rot_w_ff) * M3W'(s2_cy_ff);
   assign s3_wcz_in = M3W'(rot_w_ff) * M3W'(s2_cz_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_avx_ff <= s3_avx_in;
         s3_avy_ff <= s3_avy_in;
         s3_avz_ff <= s3_avz_in;
         s3_dux_ff <= s3_dux_in;
         s3_duy_ff <= s3_duy_in;
         s3_duz_ff <= s3_duz_in;
         s3_wcx_ff <= s3_wcx_in;
         s3_wcy_ff <= s3_wcy_in;
         s3_wcz_ff <= s3_wcz_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 4: rotated point, rounded to Q.12
   // ---------------------------------------------------------------------------------
   logic signed [SW-1:0] rx_sum, ry_sum, rz_sum;
   logic signed [PW-1:0] s4_px_in, s4_py_in, s4_pz_in;
   logic signed [PW-1:0] s4_px_ff, s4_py_ff, s4_pz_ff;

   assign rx_sum = SW'(s3_avx_ff) + (SW'(s3_dux_ff) <<< 1) + (SW'(s3_wcx_ff) <<< 1)
                 + SW'(8192);
   assign ry_sum = SW'(s3_avy_ff) + (SW'(s3_duy_ff) <<< 1) + (SW'(s3_wcy_ff) <<< 1)
                 + SW'(8192);
   assign rz_sum = SW'(s3_avz_ff) + (SW'(s3_duz_ff) <<< 1) + (SW'(s3_wcz_ff) <<< 1)
                 + SW'(8192);

   assign s4_px_in = PW'(rx_sum >>> 14);
   assign s4_py_in = PW'(ry_sum >>> 14);
   assign s4_pz_in = PW'(rz_sum >>> 14);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_px_ff <= s4_px_in;
         s4_py_ff <= s4_py_in;
         s4_pz_ff <= s4_pz_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 5: denominator 2D - z, and x / y clamped to +-2^36
   // ---------------------------------------------------------------------------------
   logic signed [CMPW-1:0] pxe, pye;
   logic signed [DENS-1:0] s5_den_in, s5_den_ff;
   logic signed [PCW-1:0]  s5_pxc_in, s5_pyc_in, s5_pxc_ff, s5_pyc_ff;

   assign s5_den_in = DENS'($signed({1'b0, depth_ff, 5'b0})) - DENS'(s4_pz_ff);
   assign pxe       = CMPW'(s4_px_ff);
   assign pye       = CMPW'(s4_py_ff);
   assign s5_pxc_in = (pxe > PLIM_POS) ? PCW'(PLIM_POS) :
                      (pxe < PLIM_NEG) ? PCW'(PLIM_NEG) : PCW'(pxe);
   assign s5_pyc_in = (pye > PLIM_POS) ? PCW'(PLIM_POS) :
                      (pye < PLIM_NEG) ? PCW'(PLIM_NEG) : PCW'(pye);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_den_ff <= s5_den_in;
         s5_pxc_ff <= s5_pxc_in;
         s5_pyc_ff <= s5_pyc_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 6: factor range check. Numerator is depth << 17, so its low 16 bits are
   // zero and the divider starts from depth << 1. A quotient at or above the ceiling
   // is caught here (N >= 40960*den), which also keeps the 16 quotient bits enough.
   // Index 0 of the divider arrays is this stage.
   // ---------------------------------------------------------------------------------
   logic [RW-1:0]   den_mag;
   logic [CHKW-1:0] num_chk, ceil_chk;
   fmode_type       mode_in;

   fmode_type             dv_mode_ff [QW+1];
   logic [RW-1:0]         dv_den_ff  [QW+1];
   logic [RW-1:0]         dv_rem_ff  [QW+1];
   logic [RW-1:0]         dv_rem_in  [QW+1];
   logic [QW-1:0]         dv_q_ff    [QW+1];
   logic [QW-1:0]         dv_q_in    [QW+1];
   logic signed [PCW-1:0] dv_pxc_ff  [QW+1];
   logic signed [PCW-1:0] dv_pyc_ff  [QW+1];

   assign den_mag  = RW'(s5_den_ff);
   assign num_chk  = CHKW'({depth_ff, 17'b0});
   assign ceil_chk = (CHKW'(den_mag) << 15) + (CHKW'(den_mag) << 13);

   always_comb begin
      if (s5_den_ff == '0) begin
         mode_in = FMODE_MAX;
      end else if (s5_den_ff[DENS-1]) begin
         mode_in = FMODE_MIN;
      end else if (num_chk >= ceil_chk) begin
         mode_in = FMODE_MAX;
      end else begin
         mode_in = FMODE_DIV;
      end
   end

   assign dv_rem_in[0] = (mode_in == FMODE_DIV) ? RW'({depth_ff, 1'b0}) : '0;
   assign dv_q_in[0]   = '0;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_mode_ff[0] <= mode_in;
         dv_den_ff[0]  <= (mode_in == FMODE_DIV) ? den_mag : RW'(1);
         dv_rem_ff[0]  <= dv_rem_in[0];
         dv_q_ff[0]    <= dv_q_in[0];
         dv_pxc_ff[0]  <= s5_pxc_ff;
         dv_pyc_ff[0]  <= s5_pyc_ff;
      end
   end

   // Restoring divider, one quotient bit per stage, MSB first
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [RW:0] shl;
      logic        ge;

      assign shl          = {dv_rem_ff[k-1], 1'b0};
      assign ge           = (shl >= {1'b0, dv_den_ff[k-1]});
      assign dv_rem_in[k] = ge ? RW'(shl - {1'b0, dv_den_ff[k-1]}) : RW'(shl);
      assign dv_q_in[k]   = {dv_q_ff[k-1][QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            dv_mode_ff[k] <= dv_mode_ff[k-1];
            dv_den_ff[k]  <= dv_den_ff[k-1];
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_q_ff[k]    <= dv_q_in[k];
            dv_pxc_ff[k]  <= dv_pxc_ff[k-1];
            dv_pyc_ff[k]  <= dv_pyc_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // T1: factor select and scale*factor
   // ---------------------------------------------------------------------------------
   logic [15:0]           f_sel;
   logic [31:0]           t1_sfm_in, t1_sfm_ff;
   logic signed [PCW-1:0] t1_pxc_ff, t1_pyc_ff;

   always_comb begin
      unique case (dv_mode_ff[QW])
         FMODE_DIV: f_sel = (dv_q_ff[QW] < FACTOR_MIN) ? FACTOR_MIN : dv_q_ff[QW];
         FMODE_MAX: f_sel = FACTOR_MAX;
         FMODE_MIN: f_sel = FACTOR_MIN;
         default:   f_sel = FACTOR_MIN;
      endcase
   end

   assign t1_sfm_in = 32'(scale_ff) * 32'(f_sel);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t1_sfm_ff <= t1_sfm_in;
         t1_pxc_ff <= dv_pxc_ff[QW];
         t1_pyc_ff <= dv_pyc_ff[QW];
      end
   end

   // ---------------------------------------------------------------------------------
   // T2: sf rounded to Q.12
   // ---------------------------------------------------------------------------------
   logic [SFW-1:0]        t2_sf_in, t2_sf_ff;
   logic signed [PCW-1:0] t2_pxc_ff, t2_pyc_ff;

   assign t2_sf_in = SFW'((t1_sfm_ff + 32'd32) >> 6);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t2_sf_ff  <= t2_sf_in;
         t2_pxc_ff <= t1_pxc_ff;
         t2_pyc_ff <= t1_pyc_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // T3: coordinate * sf, split into a signed high and an unsigned low partial product
   // ---------------------------------------------------------------------------------
   logic signed [HPW-1:0] t3_phx_in, t3_phy_in, t3_phx_ff, t3_phy_ff;
   logic [LPW-1:0]        t3_plx_in, t3_ply_in, t3_plx_ff, t3_ply_ff;

   assign t3_phx_in = HPW'($signed(t2_pxc_ff[PCW-1:LW])) * HPW'($signed({1'b0, t2_sf_ff}));
   assign t3_phy_in = HPW'($signed(t2_pyc_ff[PCW-1:LW])) * HPW'($signed({1'b0, t2_sf_ff}));
   assign t3_plx_in = LPW'(t2_pxc_ff[LW-1:0]) * LPW'(t2_sf_ff);
   assign t3_ply_in = LPW'(t2_pyc_ff[LW-1:0]) * LPW'(t2_sf_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t3_phx_ff <= t3_phx_in;
         t3_phy_ff <= t3_phy_in;
         t3_plx_ff <= t3_plx_in;
         t3_ply_ff <= t3_ply_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // T4: recombine and round Q.24 down to Q.4
   // ---------------------------------------------------------------------------------
   logic signed [FULLW-1:0] fullx, fully;
   logic signed [SXW-1:0]   t4_sx_in, t4_sy_in, t4_sx_ff, t4_sy_ff;

   assign fullx = (FULLW'(t3_phx_ff) <<< LW) + FULLW'($signed({1'b0, t3_plx_ff}))
                + FULLW'(524288);
   assign fully = (FULLW'(t3_phy_ff) <<< LW) + FULLW'($signed({1'b0, t3_ply_ff}))
                + FULLW'(524288);
   assign t4_sx_in = SXW'(fullx >>> 20);
   assign t4_sy_in = SXW'(fully >>> 20);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t4_sx_ff <= t4_sx_in;
         t4_sy_ff <= t4_sy_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Offset, saturation, output register and skid register
   // ---------------------------------------------------------------------------------
   logic signed [OW-1:0] ox, oy;
   rsp_data_type         res_data;
   rsp_data_type         rsp_data_ff, rsp_data_in, skid_data_ff;
   logic                 rsp_load, rsp_from_skid, skid_load;

   assign ox = OW'(offset_x_ff) + OW'(t4_sx_ff);
   assign oy = OW'(offset_y_ff) - OW'(t4_sy_ff);

   assign res_data.screen_x = (ox > OW'(32767))  ? 16'sh7FFF :
                              (ox < OW'(-32768)) ? 16'sh8000 : ox[15:0];
   assign res_data.screen_y = (oy > OW'(32767))  ? 16'sh7FFF :
                              (oy < OW'(-32768)) ? 16'sh8000 : oy[15:0];

   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      skid_vld_in   = skid_vld_ff;
      rsp_load      = 1'b0;
      rsp_from_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_vld_ff) begin
         // pipe is halted; drain skid into the output register
         if (rsp_ready) begin
            rsp_load      = 1'b1;
            rsp_from_skid = 1'b1;
            skid_vld_in   = 1'b0;
         end
      end else if (rsp_vld_ff && !rsp_ready) begin
         if (vld_ff[NP-1]) begin
            skid_load   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else begin
         rsp_vld_in = vld_ff[NP-1];
         rsp_load   = vld_ff[NP-1];
      end
   end

   assign rsp_data_in = rsp_from_skid ? skid_data_ff : res_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (skid_load) begin
         skid_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IDX_DIVN] |-> (f_sel >= FACTOR_MIN) && (f_sel <= FACTOR_MAX))
      else $error("perspective factor outside [0.1, 10]");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IDX_DIVN] && (dv_mode_ff[QW] == FMODE_DIV) |-> dv_rem_ff[QW] < dv_den_ff[QW])
      else $error("divider remainder not below denominator");

   a_div_quotient: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IDX_DIVN] && (dv_mode_ff[QW] == FMODE_DIV) |-> dv_q_ff[QW] < FACTOR_MAX)
      else $error("divider quotient reached the ceiling missed by the range check");

   a_skid_needs_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_ready))
      else $error("skid register filled without an output stall");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid register holds a result while the output register is empty");

endmodule

`default_nettype wire

// ===== sim/tb_quaternion_vertex_projection_core.sv =====
// Self-checking testbench for quaternion_vertex_projection_core: a directed table, then
// randomized register settings and vertex streams with idling, checked by a local model.
// Depends on qvp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_quaternion_vertex_projection_core
   import qvp_pkg::*;
();

   localparam int HOLD_CYCLES    = 300;  // long rsp stall, fills the pipe and the skid
   localparam int DRAIN_CYCLES   = 40;   // pipe is 26 deep, leave room for strays
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_VERTICES = 55;

   localparam logic signed [15:0] Q_EDGE [3] = '{-16'sd16384, 16'sd0, 16'sd16384};

   // ---------------------------------------------------------------------------------------
   // Directed stimulus table. Vertex rows either carry a hand-computed screen point
   // (ROW_CHECKED) or take theirs from the model (ROW_VERTEX). ROW_REG rows write a
   // register once everything in flight has come back.
   // ---------------------------------------------------------------------------------------
   typedef enum logic [1:0] {
      ROW_VERTEX,
      ROW_CHECKED,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [CSR_INDEX_WIDTH-1:0]     index;
      logic [15:0]                    wdata;
      logic signed [COORD_WIDTH-1:0]  vx;
      logic signed [COORD_WIDTH-1:0]  vy;
      logic signed [COORD_WIDTH-1:0]  vz;
      logic signed [15:0]             sx;
      logic signed [15:0]             sy;
   } stim_row_type;

   localparam int N_DIRECTED = 46;

   // At reset: identity rotation, depth 3.0 (2D = 24576 at Q.12), scale 100, offsets 0,
   // so factor is 1.0 at z = 0 and one model unit maps to 1600 (100 px in Q12.4).
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{ROW_CHECKED, '0, '0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{ROW_CHECKED, '0, '0, 16'sd4096, 16'sd0, 16'sd0, 16'sd1600, 16'sd0},
      '{ROW_CHECKED, '0, '0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, -16'sd1600},
      '{ROW_CHECKED, '0, '0, 16'sd32767, 16'sd0, 16'sd0, 16'sd12800, 16'sd0},
      '{ROW_CHECKED, '0, '0, 16'sh8000, 16'sh8000, 16'sd0, -16'sd12800, 16'sd12800},
      // z past the camera: negative denominator, factor 0.1
      '{ROW_CHECKED, '0, '0, 16'sd4096, 16'sd0, 16'sd32767, 16'sd160, 16'sd0},
      // z exactly at 2D: zero denominator, factor 10
      '{ROW_CHECKED, '0, '0, 16'sd4096, 16'sd0, 16'sd24576, 16'sd16000, 16'sd0},
      '{ROW_CHECKED, '0, '0, 16'sd32767, 16'sd0, 16'sd24576, 16'sd32767, 16'sd0},
      '{ROW_CHECKED, '0, '0, 16'sh8000, 16'sh8000, 16'sd24576, 16'sh8000, 16'sd32767},
      // offsets at their extremes
      '{ROW_REG, CSR_OFFSET_X, 16'h7FFF, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_OFFSET_Y, 16'h8000, '0, '0, '0, '0, '0},
      '{ROW_CHECKED, '0, '0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sh8000},
      '{ROW_VERTEX, '0, '0, 16'sd4096, 16'sd4096, 16'sd0, '0, '0},
      '{ROW_REG, CSR_OFFSET_X, 16'h8000, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_OFFSET_Y, 16'h7FFF, '0, '0, '0, '0, '0},
      '{ROW_CHECKED, '0, '0, -16'sd4096, -16'sd4096, 16'sd0, 16'sh8000, 16'sd32767},
      // zero scale collapses everything onto the offsets
      '{ROW_REG, CSR_SCALE, 16'h0000, '0, '0, '0, '0, '0},
      '{ROW_CHECKED, '0, '0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sh8000, 16'sd32767},
      '{ROW_REG, CSR_SCALE, 16'hFFFF, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_OFFSET_X, 16'h0000, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_OFFSET_Y, 16'h0000, '0, '0, '0, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sd4096, -16'sd4096, -16'sd4096, '0, '0},
      // depth 0 with z 0: zero denominator again, then quotient 0 floored to 0.1
      '{ROW_REG, CSR_DEPTH, 16'h0000, '0, '0, '0, '0, '0},
      '{ROW_CHECKED, '0, '0, 16'sd4096, 16'sd0, 16'sd0, 16'sd32767, 16'sd0},
      '{ROW_VERTEX, '0, '0, 16'sd4096, 16'sd0, -16'sd4096, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sd0, 16'sd4096, 16'sd4096, '0, '0},
      '{ROW_REG, CSR_DEPTH, 16'hFFFF, '0, '0, '0, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sd32767, 16'sh8000, 16'sh8000, '0, '0},
      // non-unit quaternions: |q|^2 = 4, all positive then all negative
      '{ROW_REG, CSR_ROT_W, 16'd16384, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_X, 16'd16384, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_Y, 16'd16384, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_Z, 16'd16384, '0, '0, '0, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sd4096, 16'sd2048, -16'sd1024, '0, '0},
      '{ROW_REG, CSR_ROT_W, 16'hC000, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_X, 16'hC000, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_Y, 16'hC000, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_Z, 16'hC000, '0, '0, '0, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sh8000, 16'sd32767, 16'sd1, '0, '0},
      // 90 degrees about z
      '{ROW_REG, CSR_ROT_W, 16'd11585, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_X, 16'd0, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_Y, 16'd0, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_ROT_Z, 16'd11585, '0, '0, '0, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sd4096, 16'sd0, 16'sd0, '0, '0},
      '{ROW_REG, CSR_DEPTH, 16'd768, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_SCALE, 16'd6400, '0, '0, '0, '0, '0},
      '{ROW_VERTEX, '0, '0, 16'sd1, -16'sd1, -16'sd2, '0, '0}
   };

   // ---------------------------------------------------------------------------------------
   // DUT connections
   // ---------------------------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   req_data_type                req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   rsp_data_type                rsp_data;
   logic                        csr_we;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [15:0]                 csr_wdata;

   quaternion_vertex_projection_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Shadow copy of the registers, kept in step with every csr write
   // ---------------------------------------------------------------------------------------
   logic signed [15:0] q_w   = RST_ROT_W;
   logic signed [15:0] q_x   = RST_ROT_XYZ;
   logic signed [15:0] q_y   = RST_ROT_XYZ;
   logic signed [15:0] q_z   = RST_ROT_XYZ;
   logic        [15:0] depth = RST_DEPTH;
   logic        [15:0] zoom  = RST_SCALE;
   logic signed [15:0] off_x = RST_OFFSET;
   logic signed [15:0] off_y = RST_OFFSET;

   rsp_data_type pending_points [$];   // screen points still owed by the core, oldest first
   int  mismatch_count = 0;
   int  send_idle_pct  = 37;
   int  recv_idle_pct  = 51;
   bit  pressure_go    = 1'b0;

   // Arithmetic shift with round half up
   function automatic longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [15:0] sat16(longint x);
      if (x > 32767) return 16'sd32767;
      if (x < -32768) return 16'sh8000;
      return 16'(x);
   endfunction

   function automatic longint clamp_coord(longint x);
      if (x > (longint'(1) << 36)) return longint'(1) << 36;
      if (x < -(longint'(1) << 36)) return -(longint'(1) << 36);
      return x;
   endfunction

   // Rotate by q v q*, then apply the clamped perspective factor and the screen mapping
   function automatic rsp_data_type project_vertex(req_data_type v);
      longint vx, vy, vz, w, x, y, z, a14, d12, cx, cy, cz, px, py, pz;
      longint twod, den, f, sf, sx, sy, scl;
      rsp_data_type r;
      vx = v.vertex_x;  vy = v.vertex_y;  vz = v.vertex_z;
      w = q_w;  x = q_x;  y = q_y;  z = q_z;
      a14 = round_shift(w * w - x * x - y * y - z * z, 14);
      d12 = round_shift(x * vx + y * vy + z * vz, 14);
      cx  = round_shift(y * vz - z * vy, 14);
      cy  = round_shift(z * vx - x * vz, 14);
      cz  = round_shift(x * vy - y * vx, 14);
      px  = round_shift(a14 * vx + 2 * d12 * x + 2 * w * cx, 14);
      py  = round_shift(a14 * vy + 2 * d12 * y + 2 * w * cy, 14);
      pz  = round_shift(a14 * vz + 2 * d12 * z + 2 * w * cz, 14);

      twod = depth;
      twod = twod << 5;          // Q8.8 -> Q.12, times two
      den  = twod - pz;
      if (den == 0) begin
         f = FACTOR_MAX;
      end else if (den < 0) begin
         f = FACTOR_MIN;
      end else begin
         f = (twod << 12) / den;
         if (f > FACTOR_MAX) f = FACTOR_MAX;
         if (f < FACTOR_MIN) f = FACTOR_MIN;
      end

      scl = zoom;
      sf  = round_shift(scl * f, 6);
      sx  = round_shift(clamp_coord(px) * sf, 20);
      sy  = round_shift(clamp_coord(py) * sf, 20);
      r.screen_x = sat16(longint'(off_x) + sx);
      r.screen_y = sat16(longint'(off_y) - sy);
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
      case ($urandom_range(9))
         0:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
         1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
         2, 3:    return COORD_WIDTH'($urandom);
         default: return COORD_WIDTH'(int'($urandom_range(16383)) - 8192);  // within +-2.0
      endcase
   endfunction

   function automatic logic [15:0] rand_offset();
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom);
         default: return 16'(int'($urandom_range(8000)) - 4000);
      endcase
   endfunction

   // One register write per edge; csr_we stays high across back-to-back writes and is
   // dropped when send_vertex offers the next vertex.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ROT_W:    q_w   = val;
         CSR_ROT_X:    q_x   = val;
         CSR_ROT_Y:    q_y   = val;
         CSR_ROT_Z:    q_z   = val;
         CSR_DEPTH:    depth = val;
         CSR_SCALE:    zoom  = val;
         CSR_OFFSET_X: off_x = val;
         CSR_OFFSET_Y: off_y = val;
         default:      ;
      endcase
   endtask

   // Offer one vertex, with a random lead-in gap; valid stays up after the transfer so
   // the next call can stream back to back.
   task automatic send_vertex(input req_data_type v, input bit typed, input rsp_data_type want);
      csr_we <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do @(posedge clock); while (!req_ready);
      pending_points.push_back(typed ? want : project_vertex(v));
   endtask

   // Stop offering and wait for every owed point; every vertex yields one, so an empty
   // queue means the pipe is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold once pressure_go is raised so the
   // pipe and skid fill and req_ready drops while the sender keeps pushing.
   // ---------------------------------------------------------------------------------------
   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_go && !held) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Checker: every rsp transfer is matched against the oldest owed point
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected transfer: screen_x %0d screen_y %0d",
                   rsp_data.screen_x, rsp_data.screen_y);
            mismatch_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.screen_x !== want.screen_x) begin
               $error("screen_x: expected %0d, got %0d", want.screen_x, rsp_data.screen_x);
               mismatch_count++;
            end
            if (rsp_data.screen_y !== want.screen_y) begin
               $error("screen_y: expected %0d, got %0d", want.screen_y, rsp_data.screen_y);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      logic signed [15:0] qv [4];
      real                c [4];
      real                mag;
      logic [15:0]        val;
      req_data_type       v;
      rsp_data_type       want;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, run under the first idling mix
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_REG) begin
            wait_idle();
            write_reg(DIRECTED[i].index, DIRECTED[i].wdata);
         end else begin
            v.vertex_x = DIRECTED[i].vx;
            v.vertex_y = DIRECTED[i].vy;
            v.vertex_z = DIRECTED[i].vz;
            want.screen_x = DIRECTED[i].sx;
            want.screen_y = DIRECTED[i].sy;
            send_vertex(v, DIRECTED[i].kind == ROW_CHECKED, want);
         end
      end

      // Random phases: new settings for every register, then a burst of vertices.
      // Idling: sender 37 / receiver 51, then swapped, then none.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase * 3 / RANDOM_PHASES)
            0:       begin send_idle_pct = 37; recv_idle_pct = 51; end
            1:       begin send_idle_pct = 51; recv_idle_pct = 37; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase

         wait_idle();

         // Mostly unit quaternions; identity, corner values and raw ones now and then
         case ($urandom_range(9))
            7: qv = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
            8: foreach (qv[k]) qv[k] = Q_EDGE[$urandom_range(2)];
            9: foreach (qv[k]) qv[k] = 16'(int'($urandom_range(32768)) - 16384);
            default: begin
               mag = 0.0;
               foreach (c[k]) begin
                  c[k] = int'($urandom_range(32768)) - 16384;
                  mag += c[k] * c[k];
               end
               mag = $sqrt(mag);
               if (mag < 1.0) qv = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
               else foreach (qv[k]) qv[k] = 16'($rtoi(c[k] * 16384.0 / mag));
            end
         endcase
         write_reg(CSR_ROT_W, qv[0]);
         write_reg(CSR_ROT_X, qv[1]);
         write_reg(CSR_ROT_Y, qv[2]);
         write_reg(CSR_ROT_Z, qv[3]);

         case ($urandom_range(5))
            0:       val = 16'd1;
            1:       val = 16'hFFFF;
            2:       val = 16'($urandom_range(65535, 1));
            default: val = 16'($urandom_range(2048, 64));
         endcase
         write_reg(CSR_DEPTH, val);

         case ($urandom_range(5))
            0:       val = 16'd0;
            1:       val = 16'hFFFF;
            2:       val = 16'($urandom);
            default: val = 16'($urandom_range(12800, 1000));
         endcase
         write_reg(CSR_SCALE, val);
         write_reg(CSR_OFFSET_X, rand_offset());
         write_reg(CSR_OFFSET_Y, rand_offset());

         // Long receiver hold during a no-idle phase
         if (phase == RANDOM_PHASES - 2) pressure_go = 1'b1;

         repeat (PHASE_VERTICES) begin
            v.vertex_x = rand_coord();
            v.vertex_y = rand_coord();
            v.vertex_z = rand_coord();
            send_vertex(v, 1'b0, want);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_points.size() == 0)
         $display("quaternion_vertex_projection_core: match");
      else
         $display("quaternion_vertex_projection_core: mismatch");
      $finish;
   end

   // Watchdog, far above the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("quaternion_vertex_projection_core: mismatch");
      $finish;
   end

endmodule
